// ----- hdl/vmc_pkg.sv -----
// Package: widths and step counts for the vector magnitude clamp.
`default_nettype none
package vmc_pkg;
   localparam int COMP_W     = 24;
   localparam int LIM_W      = 23;
   localparam int NCOMP      = 3;
   localparam int MAG_W      = COMP_W;
   localparam int SQR_W      = 2 * COMP_W - 1;
   localparam int SUM_W      = 2 * COMP_W;
   localparam int NUM_W      = COMP_W + LIM_W - 1;
   localparam int LIM2_W     = 2 * LIM_W;
   localparam int SQRT_STEPS = SUM_W / 2;
   localparam int ROOT_W     = SQRT_STEPS + 1;
   localparam int DIV_STEPS  = LIM_W;
   localparam int QUO_W      = LIM_W;
   localparam int DIV_W      = ROOT_W + DIV_STEPS;
   localparam int ADDR_W     = 3;
   localparam int DATA_W     = 32;
   localparam logic ADDR_LIMIT = 1'b0;
endpackage
`default_nettype wire

// ----- hdl/vmc_if.sv -----
// Stream interfaces: input force word and capped result word.
`default_nettype none
interface vmc_req_if;
   logic valid;
   logic ready;
   logic signed [vmc_pkg::COMP_W-1:0] force_x;
   logic signed [vmc_pkg::COMP_W-1:0] force_y;
   logic signed [vmc_pkg::COMP_W-1:0] force_z;
   modport source  (output valid, force_x, force_y, force_z, input ready);
   modport sink    (input valid, force_x, force_y, force_z, output ready);
   modport monitor (input valid, ready, force_x, force_y, force_z);
endinterface

interface vmc_rsp_if;
   logic valid;
   logic ready;
   logic signed [vmc_pkg::COMP_W-1:0] capped_x;
   logic signed [vmc_pkg::COMP_W-1:0] capped_y;
   logic signed [vmc_pkg::COMP_W-1:0] capped_z;
   logic was_capped;
   modport source  (output valid, capped_x, capped_y, capped_z, was_capped, input ready);
   modport sink    (input valid, capped_x, capped_y, capped_z, was_capped, output ready);
   modport monitor (input valid, ready, capped_x, capped_y, capped_z, was_capped);
endinterface
`default_nettype wire

// ----- hdl/vector_magnitude_clamp_top.sv -----
// Top level: pipelined 3D vector length clamp with APB-style limit register.
//
//   channel | direction | handshake        | word
//   req     | in        | valid/ready      | force_x, force_y, force_z
//   rsp     | out       | valid/ready      | capped_x/y/z, was_capped
//   csr     | in/out    | psel/penable     | magnitude_limit at address 0
//
// One word per cycle unless the output stalls; the pipeline has 3 setup stages, 24 square
// root stages (one root bit each), 1 round-up stage, 23 divider stages (one
// quotient bit each), 1 output stage. Synchronous reset clears valid bits
// and the limit. A stalled output freezes the whole pipeline in place.
`default_nettype none
module vector_magnitude_clamp_top (
   input  wire logic                      clock,
   input  wire logic                      reset,
   vmc_req_if.sink                        req,
   vmc_rsp_if.source                      rsp,
   input  wire logic                      csr_psel,
   input  wire logic                      csr_penable,
   input  wire logic                      csr_pwrite,
   input  wire logic [vmc_pkg::ADDR_W-1:0] csr_paddr,
   input  wire logic [vmc_pkg::DATA_W-1:0] csr_pwdata,
   output logic      [vmc_pkg::DATA_W-1:0] csr_prdata,
   output logic                           csr_pready
);
   import vmc_pkg::*;

   typedef struct packed {
      logic [NCOMP-1:0][COMP_W-1:0] comp;
      logic [NCOMP-1:0][NUM_W-1:0]  num;
      logic                         cap;
   } carry_type;

   logic [LIM_W-1:0] lim_ff;
   logic adv;

   // csr
   assign csr_pready = 1'b1;
   assign csr_prdata = (csr_paddr[2] == ADDR_LIMIT) ?
                       {{(DATA_W-LIM_W){1'b0}}, lim_ff} : '0;
   always_ff @(posedge clock) begin
      if (reset) begin
         lim_ff <= '0;
      end else if (csr_psel && csr_penable && csr_pwrite && csr_pready &&
                   csr_paddr[2] == ADDR_LIMIT) begin
         lim_ff <= csr_pwdata[LIM_W-1:0];
      end
   end

   // stage registers
   logic                          a_valid_ff;
   logic [NCOMP-1:0][COMP_W-1:0]  a_comp_ff, a_comp_in;
   logic [NCOMP-1:0][MAG_W-1:0]   a_mag_ff, a_mag_in;
   logic [LIM_W-1:0]              a_lim_ff;

   logic                          b_valid_ff;
   logic [NCOMP-1:0][COMP_W-1:0]  b_comp_ff;
   logic [NCOMP-1:0][SQR_W-1:0]   b_sq_ff, b_sq_in;
   logic [NCOMP-1:0][NUM_W-1:0]   b_num_ff, b_num_in;
   logic [LIM2_W-1:0]             b_lim2_ff, b_lim2_in;
   logic                          b_limnz_ff;

   logic                          c_valid_ff;
   logic [SUM_W-1:0]              c_sum_ff, c_sum_in;
   carry_type                     c_carry_ff, c_carry_in;

   logic      [SQRT_STEPS-1:0]    s_valid_ff;
   logic      [SUM_W-1:0]         s_rem_ff   [SQRT_STEPS], s_rem_in   [SQRT_STEPS];
   logic      [SQRT_STEPS-1:0]    s_root_ff  [SQRT_STEPS], s_root_in  [SQRT_STEPS];
   carry_type                     s_carry_ff [SQRT_STEPS];

   logic                          d_valid_ff;
   logic [ROOT_W-1:0]             d_den_ff, d_den_in;
   carry_type                     d_carry_ff;

   logic [DIV_STEPS-1:0]          v_valid_ff;
   logic [NCOMP-1:0][NUM_W-1:0]   v_rem_ff [DIV_STEPS], v_rem_in [DIV_STEPS];
   logic [NCOMP-1:0][QUO_W-1:0]   v_quo_ff [DIV_STEPS], v_quo_in [DIV_STEPS];
   logic [ROOT_W-1:0]             v_den_ff [DIV_STEPS];
   carry_type                     v_carry_ff [DIV_STEPS];

   logic                          o_valid_ff;
   logic [NCOMP-1:0][COMP_W-1:0]  o_comp_ff, o_comp_in;
   logic                          o_cap_ff;

   assign adv       = !o_valid_ff || rsp.ready;
   assign req.ready = adv;

   // stage a: magnitudes
   always_comb begin
      a_comp_in[0] = req.force_x;
      a_comp_in[1] = req.force_y;
      a_comp_in[2] = req.force_z;
      for (int i = 0; i < NCOMP; i++) begin
         a_mag_in[i] = a_comp_in[i][COMP_W-1] ? (~a_comp_in[i] + 1'b1) : a_comp_in[i];
      end
   end

   // stage b: squares and products
   always_comb begin
      for (int i = 0; i < NCOMP; i++) begin
         b_sq_in[i]  = SQR_W'(a_mag_ff[i] * a_mag_ff[i]);
         b_num_in[i] = NUM_W'(a_mag_ff[i] * a_lim_ff);
      end
      b_lim2_in = LIM2_W'(a_lim_ff * a_lim_ff);
   end

   // stage c: length squared and cap decision
   always_comb begin
      c_sum_in = SUM_W'(b_sq_ff[0]) + SUM_W'(b_sq_ff[1]) + SUM_W'(b_sq_ff[2]);
      c_carry_in.comp = b_comp_ff;
      c_carry_in.num  = b_num_ff;
      c_carry_in.cap  = b_limnz_ff && (c_sum_in > SUM_W'(b_lim2_ff));
   end

   // square root, one bit per stage, remainder kept as sum - root^2
   always_comb begin
      logic [SUM_W-1:0]      rp;
      logic [SQRT_STEPS-1:0] qp;
      logic [SUM_W:0]        inc;
      for (int i = 0; i < SQRT_STEPS; i++) begin
         rp  = (i == 0) ? c_sum_ff : s_rem_ff[i-1];
         qp  = (i == 0) ? '0 : s_root_ff[i-1];
         inc = ((SUM_W+1)'(qp) << (SQRT_STEPS - i)) +
               ((SUM_W+1)'(1) << (2 * (SQRT_STEPS - 1 - i)));
         if ({1'b0, rp} >= inc) begin
            s_rem_in[i]  = rp - inc[SUM_W-1:0];
            s_root_in[i] = qp | (SQRT_STEPS'(1) << (SQRT_STEPS - 1 - i));
         end else begin
            s_rem_in[i]  = rp;
            s_root_in[i] = qp;
         end
      end
   end

   // round root up
   assign d_den_in = ROOT_W'(s_root_ff[SQRT_STEPS-1]) +
                     ROOT_W'(s_rem_ff[SQRT_STEPS-1] != '0);

   // restoring divider, one quotient bit per stage, three lanes
   always_comb begin
      logic [NCOMP-1:0][NUM_W-1:0] rp;
      logic [NCOMP-1:0][QUO_W-1:0] qp;
      logic [ROOT_W-1:0]           dp;
      logic [DIV_W-1:0]            dsh;
      for (int j = 0; j < DIV_STEPS; j++) begin
         rp  = (j == 0) ? d_carry_ff.num : v_rem_ff[j-1];
         qp  = (j == 0) ? '0 : v_quo_ff[j-1];
         dp  = (j == 0) ? d_den_ff : v_den_ff[j-1];
         dsh = DIV_W'(dp) << (DIV_STEPS - 1 - j);
         for (int i = 0; i < NCOMP; i++) begin
            if (DIV_W'(rp[i]) >= dsh) begin
               v_rem_in[j][i] = rp[i] - dsh[NUM_W-1:0];
               v_quo_in[j][i] = qp[i] | (QUO_W'(1) << (DIV_STEPS - 1 - j));
            end else begin
               v_rem_in[j][i] = rp[i];
               v_quo_in[j][i] = qp[i];
            end
         end
      end
   end

   // output: restore signs when capped, else pass the input word through
   always_comb begin
      logic [COMP_W-1:0] q;
      for (int i = 0; i < NCOMP; i++) begin
         q = COMP_W'(v_quo_ff[DIV_STEPS-1][i]);
         if (v_carry_ff[DIV_STEPS-1].cap) begin
            o_comp_in[i] = v_carry_ff[DIV_STEPS-1].comp[i][COMP_W-1] ? (~q + 1'b1) : q;
         end else begin
            o_comp_in[i] = v_carry_ff[DIV_STEPS-1].comp[i];
         end
      end
   end

   // valid chain
   always_ff @(posedge clock) begin
      if (reset) begin
         a_valid_ff <= 1'b0;
         b_valid_ff <= 1'b0;
         c_valid_ff <= 1'b0;
         s_valid_ff <= '0;
         d_valid_ff <= 1'b0;
         v_valid_ff <= '0;
         o_valid_ff <= 1'b0;
      end else if (adv) begin
         a_valid_ff <= req.valid;
         b_valid_ff <= a_valid_ff;
         c_valid_ff <= b_valid_ff;
         s_valid_ff <= {s_valid_ff[SQRT_STEPS-2:0], c_valid_ff};
         d_valid_ff <= s_valid_ff[SQRT_STEPS-1];
         v_valid_ff <= {v_valid_ff[DIV_STEPS-2:0], d_valid_ff};
         o_valid_ff <= v_valid_ff[DIV_STEPS-1];
      end
   end

   // payload
   always_ff @(posedge clock) begin
      if (adv) begin
         a_comp_ff  <= a_comp_in;
         a_mag_ff   <= a_mag_in;
         a_lim_ff   <= lim_ff;
         b_comp_ff  <= a_comp_ff;
         b_sq_ff    <= b_sq_in;
         b_num_ff   <= b_num_in;
         b_lim2_ff  <= b_lim2_in;
         b_limnz_ff <= (a_lim_ff != '0);
         c_sum_ff   <= c_sum_in;
         c_carry_ff <= c_carry_in;
         for (int i = 0; i < SQRT_STEPS; i++) begin
            s_rem_ff[i]   <= s_rem_in[i];
            s_root_ff[i]  <= s_root_in[i];
            s_carry_ff[i] <= (i == 0) ? c_carry_ff : s_carry_ff[i-1];
         end
         d_den_ff   <= d_den_in;
         d_carry_ff <= s_carry_ff[SQRT_STEPS-1];
         for (int j = 0; j < DIV_STEPS; j++) begin
            v_rem_ff[j]   <= v_rem_in[j];
            v_quo_ff[j]   <= v_quo_in[j];
            v_den_ff[j]   <= (j == 0) ? d_den_ff : v_den_ff[j-1];
            v_carry_ff[j] <= (j == 0) ? d_carry_ff : v_carry_ff[j-1];
         end
         o_comp_ff <= o_comp_in;
         o_cap_ff  <= v_carry_ff[DIV_STEPS-1].cap;
      end
   end

   assign rsp.valid      = o_valid_ff;
   assign rsp.capped_x   = o_comp_ff[0];
   assign rsp.capped_y   = o_comp_ff[1];
   assign rsp.capped_z   = o_comp_ff[2];
   assign rsp.was_capped = o_cap_ff;
endmodule
`default_nettype wire
